[rtl/core/flcp_pkg.sv]
package flcp_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_PIXEL  = 3'd1,
        OP_LINE   = 3'd2,
        OP_CIRCLE = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_STEP,
        ST_READ,
        ST_READ_WAIT,
        ST_OUT
    } t_state;

    // plot source: single pixel, line point, or circle point in one of eight octants
    typedef enum logic [1:0] {
        SRC_PIXEL,
        SRC_LINE,
        SRC_CIRCLE
    } t_src;

    typedef struct packed {
        logic       load;       // latch input item
        logic       clr_start;  // reset clear address
        logic       clr_write;  // write zero at clear address, advance
        logic       plot_rd;    // compute plot address, issue read
        logic       plot_wr;    // modify and write back
        logic       step;       // advance line / circle / octant
        logic       rd_issue;   // issue read of read_index
        logic       rd_latch;   // capture read data
        logic       out_zero;   // result is zero
        t_src       src;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic clr_done;
        logic draw_done;  // last pixel of line/circle already plotted
    } t_status;

endpackage

[rtl/core/flcp_ctrl.sv]
module flcp_ctrl
    import flcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  logic    i_out_fire,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_out_valid
);

    t_state r_state, n_state;
    t_src   r_src, n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_src   <= SRC_PIXEL;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        unique case (r_state)
            ST_INIT:      if (i_status.clr_done) n_state = ST_IDLE;
            ST_IDLE:      if (i_in_fire) n_state = ST_DECODE;
            ST_DECODE: begin
                unique case (i_status.op)
                    OP_CLEAR:  n_state = ST_CLEAR;
                    OP_PIXEL:  begin n_state = ST_PLOT_RD; n_src = SRC_PIXEL;  end
                    OP_LINE:   begin n_state = ST_PLOT_RD; n_src = SRC_LINE;   end
                    OP_CIRCLE: begin n_state = ST_PLOT_RD; n_src = SRC_CIRCLE; end
                    OP_READ:   n_state = ST_READ;
                    default:   n_state = ST_OUT;
                endcase
            end
            ST_CLEAR:     if (i_status.clr_done) n_state = ST_OUT;
            ST_PLOT_RD:   n_state = ST_PLOT_WR;
            ST_PLOT_WR:   n_state = (r_src == SRC_PIXEL) ? ST_OUT : ST_STEP;
            ST_STEP:      n_state = i_status.draw_done ? ST_OUT : ST_PLOT_RD;
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_OUT;
            ST_OUT:       if (i_out_fire) n_state = ST_IDLE;
            default:      n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.src       = r_src;
        o_cmd.load      = (r_state == ST_IDLE) && i_in_fire;
        o_cmd.clr_start = (r_state == ST_DECODE);
        o_cmd.clr_write = (r_state == ST_INIT) || (r_state == ST_CLEAR);
        o_cmd.plot_rd   = (r_state == ST_PLOT_RD);
        o_cmd.plot_wr   = (r_state == ST_PLOT_WR);
        o_cmd.step      = (r_state == ST_STEP);
        o_cmd.rd_issue  = (r_state == ST_READ);
        o_cmd.rd_latch  = (r_state == ST_READ_WAIT);
        o_cmd.out_zero  = (r_state == ST_DECODE);
        o_busy          = (r_state != ST_IDLE);
        o_out_valid     = (r_state == ST_OUT);
    end

endmodule

[rtl/core/flcp_datapath.sv]
module flcp_datapath
    import flcp_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 84,
    parameter int DISPLAY_HEIGHT = 48,
    parameter int STORE_BYTES    = 504
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [50:0] i_item,
    output t_status     o_status,
    output logic [7:0]  o_read_data
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    // latched item
    t_op        r_op;
    logic [7:0] r_xa, r_ya, r_xb, r_yb;
    logic [5:0] r_rad;
    logic       r_pv;
    logic [8:0] r_ri;

    logic [AW-1:0] r_clr;

    // line state
    logic [7:0] r_px, r_py, r_acc, r_lng, r_shrt, r_cnt;
    logic [7:0] r_sx, r_sy, r_mx, r_my;
    // circle state
    logic signed [7:0] r_cx_i, r_cy_i, r_err;
    logic [2:0]        r_oct;

    // plot target
    logic [7:0]    r_ty, w_tv;
    logic          r_tok;
    logic [AW-1:0] r_taddr;
    logic [7:0]    r_out;

    // line setup
    logic [7:0]        w_w, w_h, w_ax, w_ay;
    logic              w_xlong;
    assign w_w  = r_xb - r_xa;
    assign w_h  = r_yb - r_ya;
    assign w_ax = w_w[7] ? -w_w : w_w;
    assign w_ay = w_h[7] ? -w_h : w_h;
    assign w_xlong = w_ax > w_ay;

    // current point
    logic [7:0] w_ux, w_uy, w_qx, w_qy;
    always_comb begin
        w_ux = r_cx_i;
        w_uy = r_cy_i;
        w_qx = r_xa;
        w_qy = r_ya;
        case (i_cmd.src)
            SRC_LINE: begin w_qx = r_px; w_qy = r_py; end
            SRC_CIRCLE: begin
                case (r_oct)
                    3'd0: begin w_qx = r_xa + w_ux; w_qy = r_ya + w_uy; end
                    3'd1: begin w_qx = r_xa + w_uy; w_qy = r_ya + w_ux; end
                    3'd2: begin w_qx = r_xa - w_uy; w_qy = r_ya + w_ux; end
                    3'd3: begin w_qx = r_xa - w_ux; w_qy = r_ya + w_uy; end
                    3'd4: begin w_qx = r_xa - w_ux; w_qy = r_ya - w_uy; end
                    3'd5: begin w_qx = r_xa - w_uy; w_qy = r_ya - w_ux; end
                    3'd6: begin w_qx = r_xa + w_uy; w_qy = r_ya - w_ux; end
                    default: begin w_qx = r_xa + w_ux; w_qy = r_ya - w_uy; end
                endcase
            end
            default: ;
        endcase
    end

    logic [15:0] w_addr;
    assign w_addr = 16'(w_qy >> 3) * 16'(DISPLAY_WIDTH) + 16'(w_qx);

    // circle step
    logic signed [7:0] w_e1, w_y1, w_x1, w_e2;
    logic              w_cdone;
    always_comb begin
        w_y1 = r_cy_i;
        w_e1 = r_err;
        if (r_err <= 0) begin
            w_y1 = r_cy_i + 8'sd1;
            w_e1 = r_err + (w_y1 <<< 1) + 8'sd1;
        end
        w_x1 = r_cx_i;
        w_e2 = w_e1;
        if (w_e1 > 0) begin
            w_x1 = r_cx_i - 8'sd1;
            w_e2 = w_e1 - ((w_x1 <<< 1) + 8'sd1);
        end
        w_cdone = !(w_x1 >= w_y1);
    end

    logic [7:0] w_acc1;
    assign w_acc1 = r_acc + r_shrt;

    always_comb begin
        o_status.op       = r_op;
        o_status.clr_done = (32'(r_clr) == STORE_BYTES - 1);
        o_status.draw_done = (i_cmd.src == SRC_LINE) ? (r_cnt == r_lng)
                           : ((r_oct == 3'd7) && w_cdone);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_write && !o_status.clr_done) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_write) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.plot_wr && r_tok) begin
            r_mem[r_taddr] <= w_tv;
        end
        if (i_cmd.plot_rd) begin
            r_rdata <= r_mem[AW'(w_addr)];
        end else if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[AW'(r_ri)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_item[2:0]);
            r_xa  <= i_item[10:3];
            r_ya  <= i_item[18:11];
            r_xb  <= i_item[26:19];
            r_yb  <= i_item[34:27];
            r_rad <= i_item[40:35];
            r_pv  <= i_item[41];
            r_ri  <= i_item[50:42];
        end
        if (i_cmd.clr_start) begin
            r_px   <= r_xa;
            r_py   <= r_ya;
            r_cnt  <= '0;
            r_lng  <= w_xlong ? w_ax : w_ay;
            r_shrt <= w_xlong ? w_ay : w_ax;
            r_acc  <= (w_xlong ? w_ax : w_ay) >> 1;
            r_sx   <= (w_w == 0) ? 8'd0 : (w_w[7] ? 8'hFF : 8'd1);
            r_sy   <= (w_h == 0) ? 8'd0 : (w_h[7] ? 8'hFF : 8'd1);
            r_mx   <= w_xlong ? ((w_w == 0) ? 8'd0 : (w_w[7] ? 8'hFF : 8'd1)) : 8'd0;
            r_my   <= w_xlong ? 8'd0 : ((w_h == 0) ? 8'd0 : (w_h[7] ? 8'hFF : 8'd1));
            r_cx_i <= {2'b00, r_rad};
            r_cy_i <= '0;
            r_err  <= '0;
            r_oct  <= '0;
            r_out  <= '0;
        end
        if (i_cmd.plot_rd) begin
            r_ty    <= w_qy;
            r_tok   <= (32'(w_qx) < DISPLAY_WIDTH) && (32'(w_qy) < DISPLAY_HEIGHT)
                       && (32'(w_addr) < STORE_BYTES);
            r_taddr <= AW'(w_addr);
        end
        if (i_cmd.step) begin
            if (i_cmd.src == SRC_LINE) begin
                r_cnt <= r_cnt + 8'd1;
                if (!(w_acc1 < r_lng)) begin
                    r_acc <= w_acc1 - r_lng;
                    r_px  <= r_px + r_sx;
                    r_py  <= r_py + r_sy;
                end else begin
                    r_acc <= w_acc1;
                    r_px  <= r_px + r_mx;
                    r_py  <= r_py + r_my;
                end
            end else begin
                r_oct <= r_oct + 3'd1;
                if (r_oct == 3'd7) begin
                    r_cx_i <= w_x1;
                    r_cy_i <= w_y1;
                    r_err  <= w_e2;
                end
            end
        end
        if (i_cmd.rd_latch) begin
            r_out <= (32'(r_ri) < STORE_BYTES) ? r_rdata : 8'd0;
        end
    end

    // modify byte after read
    always_comb begin
        w_tv = r_rdata;
        if ((i_cmd.src != SRC_PIXEL) || r_pv) w_tv[r_ty[2:0]] = 1'b1;
        else                                  w_tv[r_ty[2:0]] = 1'b0;
    end

    assign o_read_data = r_out;

endmodule

[rtl/core/framebuffer_line_circle_plotter_unit.sv]
// Frame-store plotter for an 84x48 monochrome panel.
// Slave channel: one transaction carries a command (op, coordinates,
// radius, pixel value, read index) in s_axis_tdata.
// Master channel: exactly one transaction per command; m_axis_tdata is the
// stored byte for a read (zero for an index past the store), else zero.
// Commands run one at a time; s_axis_tready is high only while idle, so a
// result transaction and the next accept never fall in the same cycle.
// Steps per command, after the decode step:
//   clear  : one zero write per byte of the store
//   pixel  : read, then modify-write of one byte
//   line   : read, modify-write, step per pixel; longest axis + 1 pixels
//   circle : read, modify-write, step per plot; 8 plots per loop step
//   read   : read through the registered memory port, then latch
// The single-port frame memory's read-modify-write per pixel sets the rate.
// At reset the store is cleared by a pass that zeroes each byte; no command
// is taken during it.
// When the receiver stalls the result holds in its register and no new
// command is accepted until it is taken.
module framebuffer_line_circle_plotter_unit
    import flcp_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 84,
    parameter int DISPLAY_HEIGHT = 48,
    parameter int STORE_BYTES    = 504
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0] x_a[10:3] y_a[18:11] x_b[26:19] y_b[34:27] radius[40:35]
    // pixel_value[41] read_index[50:42], zero pad [55:51]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;
    logic    w_in_fire, w_out_fire;

    assign s_axis_tready = !w_busy;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;

    flcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_out_fire  (w_out_fire),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy),
        .o_out_valid (m_axis_tvalid)
    );

    flcp_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .STORE_BYTES    (STORE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (s_axis_tdata[50:0]),
        .o_status    (w_status),
        .o_read_data (m_axis_tdata)
    );

    // no new command while a result waits
    a_no_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accept while result pending");

    // an accepted command produces no result in the next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !m_axis_tvalid)
        else $error("result too early");

    // memory write port never used by clear and plot together
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.clr_write && w_cmd.plot_wr))
        else $error("write port conflict");

endmodule
